>>> design/baro_altitude_vertical_speed_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric altitude block
// Shared immediate-style wrappers around concurrent properties.
// ----------------------------------------------------------------------------
`ifndef BARO_ALTITUDE_VERTICAL_SPEED_MACROS_SVH
`define BARO_ALTITUDE_VERTICAL_SPEED_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BAVS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BAVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bavs_pkg.sv
// ----------------------------------------------------------------------------
// bavs_pkg
// Widths, constants and the elaboration-time power table of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bavs_pkg;

  localparam int HIST_DEPTH = 8;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int POW_PTS    = 64;
  localparam int POW_IDX_W  = $clog2(POW_PTS);
  localparam int PRES_W     = 17;
  localparam int TIME_W     = 32;
  localparam int ALT_W      = 24;
  localparam int VEL_W      = 21;
  localparam int PEAK_W     = 23;
  localparam int DIV_W      = 34;
  localparam int DVS_W      = 32;

  localparam logic [PRES_W-1:0] P0_RESET = 17'd101325;
  localparam longint ALT_MAX = 64'sd5000000;
  localparam longint ALT_MIN = -64'sd500000;
  localparam logic [DIV_W-1:0] VEL_MAX = 34'd1000000;

  typedef logic [PRES_W-1:0] pow_tab_t [0:POW_PTS];
  typedef longint unsigned chain_t [0:29];

  function automatic longint unsigned isqrt64(longint unsigned val);
    longint unsigned v, res, bit_v;
    v = val;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned log2_q30(longint unsigned x);
    int n;
    longint unsigned m, r;
    n = 0;
    while (n < 40 && (x >> (n + 1)) != 0) n++;
    m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
    r = longint'(n) << 30;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << (30 - i));
      end
    end
    return r;
  endfunction

  function automatic longint unsigned power_q16(longint unsigned x, chain_t ch);
    longint l, pe, e;
    longint unsigned u, ip, fr, mant;
    int sh;
    l = longint'(log2_q30(x)) - (64'sd16 <<< 30);
    // Scale by the exponent in Q24, truncating toward zero
    pe = l * 64'sd3192704;
    e = (pe >= 0) ? (pe >>> 24) : -((-pe) >>> 24);
    u = longint'(e + (64'sd8 <<< 30));
    ip = u >> 30;
    fr = u & ((64'd1 << 30) - 1);
    mant = 64'd1 << 30;
    for (int i = 0; i < 30; i++)
      if (((fr >> (29 - i)) & 64'd1) != 0) mant = (mant * ch[i]) >> 30;
    if (ip > 21) ip = 21;
    sh = 22 - int'(ip);
    return (mant + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic pow_tab_t build_pow_table();
    pow_tab_t tab;
    chain_t ch;
    longint unsigned pv;
    ch[0] = isqrt64(64'd1 << 61);
    for (int i = 1; i < 30; i++) ch[i] = isqrt64(ch[i-1] << 30);
    tab[0] = '0;
    for (int k = 1; k <= POW_PTS; k++) begin
      pv = power_q16((longint'(k) << 17) >> POW_IDX_W, ch);
      tab[k] = pv[PRES_W-1:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_table();

endpackage

`default_nettype wire

>>> design/bavs_div.sv
// ----------------------------------------------------------------------------
// bavs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bavs_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bavs_pkg::DIV_W-1:0] dividend,
  input  wire logic [bavs_pkg::DVS_W-1:0] divisor,
  output logic                           done,
  output logic [bavs_pkg::DIV_W-1:0]     quotient
);
  import bavs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and try a subtraction
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> design/baro_altitude_vertical_speed.sv
// Each input transaction passes through the shared bit-serial divider twice when
// the climb rate is recomputed (ratio, then velocity), and only once, for the
// ratio, when the velocity holds. The block takes one item at a time: the next
// input is taken once the result sits in the output register. Reset (rst_n,
// synchronous) empties the history ring through per-slot valid bits and loads
// ground pressure 101325 Pa.
// ----------------------------------------------------------------------------
// baro_altitude_vertical_speed
// Barometric altitude, peak tracking and ring-window climb rate.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_altitude_vertical_speed (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bavs_pkg::PRES_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bavs_pkg::PRES_W-1:0]   in_pressure_pa,
  input  wire logic [bavs_pkg::TIME_W-1:0]   in_time_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [bavs_pkg::ALT_W-1:0]  out_altitude_cm,
  output logic signed [bavs_pkg::VEL_W-1:0]  out_velocity_cm_s,
  output logic                               out_velocity_fresh,
  output logic [bavs_pkg::PEAK_W-1:0]        out_peak_altitude_cm
);
  import bavs_pkg::*;

  `include "baro_altitude_vertical_speed_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_RATIO, S_INTERP, S_ALT, S_RING, S_VMUL, S_VDIV, S_DONE
  } state_t;

  localparam int ENT_W = ALT_W + TIME_W;

  state_t                   state_r;
  logic [PRES_W-1:0]        p0_r;
  logic [PRES_W-1:0]        p_r;
  logic [TIME_W-1:0]        t_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [HIST_DEPTH-1:0]    slot_ok_r;
  logic [ENT_W-1:0]         ring_mem [0:HIST_DEPTH-1];
  logic [ENT_W-1:0]         rd_r;
  logic                     rd_ok_r;
  logic [PRES_W-1:0]        ratio_r;
  logic [PRES_W-1:0]        y_r;
  logic signed [42:0]       a_r;
  logic signed [ALT_W-1:0]  alt_r;
  logic signed [35:0]       prod_r;
  logic [DVS_W-1:0]         dt_r;
  logic                     go_r;
  logic signed [VEL_W-1:0]  vel_r;
  logic [PEAK_W-1:0]        peak_r;
  logic                     out_valid_r;
  logic signed [ALT_W-1:0]  out_alt_r;
  logic signed [VEL_W-1:0]  out_vel_r;
  logic                     out_fresh_r;
  logic [PEAK_W-1:0]        out_peak_r;
  logic                     fresh_r;

  logic                     in_acc;
  logic                     out_load;
  logic [SLOT_W-1:0]        oldest;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_q;
  logic [POW_IDX_W-1:0]     idx;
  logic [PRES_W-1:0]        frac;
  logic [PRES_W-1:0]        lo;
  logic [PRES_W-1:0]        hi;
  logic [PRES_W-1:0]        dlt;
  logic [2*PRES_W-1:0]      dlt_prod;
  logic [PRES_W-1:0]        y_nxt;
  logic [42:0]              a_mag;
  logic [42:0]              a_rnd;
  logic signed [43:0]       alt_full;
  logic signed [ALT_W-1:0]  alt_nxt;
  logic signed [ALT_W-1:0]  old_alt;
  logic [TIME_W-1:0]        old_t;
  logic [35:0]              prod_mag;
  logic [DIV_W-1:0]         q_sat;

  assign in_acc  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign oldest  = slot_r + 1'b1;
  assign old_alt = rd_r[ENT_W-1:TIME_W];
  assign old_t   = rd_r[TIME_W-1:0];

  // Table lookup and linear interpolation of the power
  assign idx      = ratio_r[PRES_W-1 -: POW_IDX_W];
  assign frac     = {ratio_r[PRES_W-1-POW_IDX_W:0], {POW_IDX_W{1'b0}}};
  assign lo       = POW_TAB[{1'b0, idx}];
  assign hi       = POW_TAB[{1'b0, idx} + 1'b1];
  assign dlt      = (hi >= lo) ? (hi - lo) : (lo - hi);
  assign dlt_prod = dlt * frac;
  assign y_nxt    = (hi >= lo) ? PRES_W'(lo + dlt_prod[2*PRES_W-1:PRES_W])
                               : PRES_W'(lo - dlt_prod[2*PRES_W-1:PRES_W]);

  // Round to nearest, ties away from zero, then saturate (zero when either pressure is zero)
  assign a_mag = a_r[42] ? 43'(-a_r) : 43'(a_r);
  assign a_rnd = (a_mag + 43'd32768) >> 16;
  assign alt_full = a_r[42] ? -$signed({1'b0, a_rnd}) : $signed({1'b0, a_rnd});
  always_comb begin
    if ((p_r == '0) || (p0_r == '0))           alt_nxt = '0;
    else if (alt_full > 44'(ALT_MAX))          alt_nxt = ALT_W'(ALT_MAX);
    else if (alt_full < 44'(ALT_MIN))          alt_nxt = ALT_W'(ALT_MIN);
    else                                       alt_nxt = alt_full[ALT_W-1:0];
  end

  // Shared divider operand selection
  assign prod_mag = prod_r[35] ? 36'(-prod_r) : 36'(prod_r);
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, in_pressure_pa, 16'd0};
    div_divisor  = DVS_W'(p0_r);
    if (in_acc) begin
      div_start = 1'b1;
    end else if (state_r == S_VDIV && go_r) begin
      div_start    = 1'b1;
      div_dividend = prod_mag[DIV_W-1:0];
      div_divisor  = dt_r;
    end
  end

  assign q_sat = (div_q > VEL_MAX) ? VEL_MAX : div_q;

  bavs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // History ring: read oldest on accept, write newest after altitude is known
  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= ring_mem[oldest];
    if (state_r == S_RING) ring_mem[slot_r] <= {alt_nxt, t_r};
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p0_r        <= P0_RESET;
      slot_r      <= '0;
      slot_ok_r   <= '0;
      vel_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      go_r        <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) p0_r <= cfg_wr_data;
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            p_r     <= in_pressure_pa;
            t_r     <= in_time_ms;
            rd_ok_r <= slot_ok_r[oldest];
            state_r <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (div_done) begin
            ratio_r <= (div_q > DIV_W'(17'h1FFFF)) ? 17'h1FFFF : div_q[PRES_W-1:0];
            state_r <= S_INTERP;
          end
        end
        S_INTERP: begin
          y_r     <= y_nxt;
          state_r <= S_ALT;
        end
        S_ALT: begin
          a_r     <= 43'(44'sd4433000 * ($signed({2'b0, 17'd65536}) -
                                         $signed({2'b0, y_r})));
          state_r <= S_RING;
        end
        S_RING: begin
          alt_r <= alt_nxt;
          slot_ok_r[slot_r] <= 1'b1;
          if (alt_nxt > 0 && 24'(alt_nxt) > {1'b0, peak_r}) peak_r <= PEAK_W'(alt_nxt);
          dt_r    <= t_r - old_t;
          go_r    <= rd_ok_r && (old_t != '0) && (t_r != old_t);
          state_r <= S_VMUL;
        end
        S_VMUL: begin
          prod_r <= 36'(($signed({alt_r[ALT_W-1], alt_r}) - $signed({old_alt[ALT_W-1],
                    old_alt})) * 36'sd1000);
          fresh_r <= 1'b0;
          state_r <= go_r ? S_VDIV : S_DONE;
        end
        S_VDIV: begin
          // Divider starts on the first cycle here
          go_r <= 1'b0;
          if (div_done) begin
            vel_r   <= prod_r[35] ? -$signed({1'b0, q_sat[VEL_W-2:0]})
                                  : $signed({1'b0, q_sat[VEL_W-2:0]});
            fresh_r <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_alt_r   <= alt_r;
            out_vel_r   <= vel_r;
            out_fresh_r <= fresh_r;
            out_peak_r  <= peak_r;
            slot_r      <= oldest;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_altitude_cm      = out_alt_r;
  assign out_velocity_cm_s    = out_vel_r;
  assign out_velocity_fresh   = out_fresh_r;
  assign out_peak_altitude_cm = out_peak_r;

  // Checks
  `BAVS_ASSERT_NEXT(a_acc_busy, in_acc, state_r != S_IDLE, "accepted item left sequencer idle")
  `BAVS_ASSERT_SAME(a_alt_range, out_valid_r,
    (out_alt_r >= -24'sd500000) && (out_alt_r <= 24'sd5000000), "altitude out of range")
  `BAVS_ASSERT_SAME(a_peak_hold, out_valid_r && !out_alt_r[ALT_W-1],
    {1'b0, out_peak_r} >= 24'(out_alt_r), "peak below reported altitude")

endmodule

`default_nettype wire

>>> dv/tb_baro_altitude_vertical_speed.sv
// ----------------------------------------------------------------------------
// tb_baro_altitude_vertical_speed
// Self-checking bench for the barometric altitude and climb-rate block. An
// in-bench altitude/velocity model predicts every result. Directed samples
// cover pressure and timestamp corner cases and ground-pressure extremes.
// Random traffic runs with idle cycles on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_baro_altitude_vertical_speed;
  timeunit 1ns;
  timeprecision 1ps;
  import bavs_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_ITEMS   = 2000;

  typedef struct packed {
    logic signed [ALT_W-1:0] alt;
    logic signed [VEL_W-1:0] vel;
    logic                    fresh;
    logic [PEAK_W-1:0]       peak;
  } climb_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [PRES_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PRES_W-1:0] in_pressure_pa = '0;
  logic [TIME_W-1:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ALT_W-1:0] out_altitude_cm;
  logic signed [VEL_W-1:0] out_velocity_cm_s;
  logic out_velocity_fresh;
  logic [PEAK_W-1:0] out_peak_altitude_cm;

  // Model state
  longint unsigned root_q30 [0:29];
  longint unsigned pow_curve [0:POW_PTS];
  logic [PRES_W-1:0] ground_pa;
  int signed alt_hist [0:HIST_DEPTH-1];
  logic [TIME_W-1:0] time_hist [0:HIST_DEPTH-1];
  int unsigned next_slot;
  int signed climb_rate;
  int unsigned peak_cm;

  climb_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int fresh_seen = 0;
  int unsigned cycles = 0;
  bit steady_flow = 1'b0;
  int holdoff_left = 0;
  logic [TIME_W-1:0] clock_ms;

  baro_altitude_vertical_speed dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pressure_pa(in_pressure_pa),
    .in_time_ms(in_time_ms), .out_valid(out_valid), .out_ready(out_ready),
    .out_altitude_cm(out_altitude_cm), .out_velocity_cm_s(out_velocity_cm_s),
    .out_velocity_fresh(out_velocity_fresh),
    .out_peak_altitude_cm(out_peak_altitude_cm)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint unsigned floor_sqrt(longint unsigned val);
    longint unsigned v, acc, b;
    v = val;
    acc = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v = v - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  // log2 in Q30 by repeated squaring of the normalized mantissa
  function automatic longint unsigned log2_fix(longint unsigned x);
    int msb;
    longint unsigned mant, acc;
    msb = 0;
    while (msb < 40 && (x >> (msb + 1)) != 0) msb++;
    mant = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
    acc = longint'(msb) << 30;
    for (int i = 1; i <= 30; i++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        acc = acc | (64'd1 << (30 - i));
      end
    end
    return acc;
  endfunction

  // Q16 x to the 0.1903, rounded to Q16
  function automatic longint unsigned pow_exp(longint unsigned x);
    longint lg, ex;
    longint unsigned u, whole, part, mant;
    int sh;
    lg = longint'(log2_fix(x)) - (longint'(16) << 30);
    ex = (lg * 64'sd3192704) / (longint'(1) << 24);
    u = longint'(ex + (longint'(8) << 30));
    whole = u >> 30;
    part = u & ((64'd1 << 30) - 1);
    mant = 64'd1 << 30;
    for (int i = 0; i < 30; i++)
      if (part[29 - i]) mant = (mant * root_q30[i]) >> 30;
    if (whole > 21) whole = 21;
    sh = 22 - int'(whole);
    return (mant + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic int signed altitude_cm_of(logic [PRES_W-1:0] p);
    longint unsigned r, pos, idx, frac, lo, hi, y;
    longint a, h;
    if (p == 0 || ground_pa == 0) return 0;
    r = (longint'(p) << 16) / ground_pa;
    if (r > 64'h1FFFF) r = 64'h1FFFF;
    pos = r * POW_PTS;
    idx = pos >> 17;
    frac = pos & 64'h1FFFF;
    lo = pow_curve[idx];
    hi = pow_curve[idx + 1];
    y = (hi >= lo) ? lo + (((hi - lo) * frac) >> 17) : lo - (((lo - hi) * frac) >> 17);
    a = 64'sd4433000 * (64'sd65536 - longint'(y));
    h = (a >= 0) ? (a + 32768) / 65536 : -((-a + 32768) / 65536);
    if (h > ALT_MAX) h = ALT_MAX;
    if (h < ALT_MIN) h = ALT_MIN;
    return int'(h);
  endfunction

  task automatic model_reset();
    ground_pa = P0_RESET;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      alt_hist[i] = 0;
      time_hist[i] = '0;
    end
    next_slot = 0;
    climb_rate = 0;
    peak_cm = 0;
    root_q30[0] = floor_sqrt(64'd1 << 61);
    for (int i = 1; i < 30; i++) root_q30[i] = floor_sqrt(root_q30[i-1] << 30);
    pow_curve[0] = 0;
    for (int k = 1; k <= POW_PTS; k++) pow_curve[k] = pow_exp((longint'(k) << 17) / POW_PTS);
  endtask

  // Advance the model by one sample and queue its result
  task automatic predict_climb(logic [PRES_W-1:0] p, logic [TIME_W-1:0] t);
    int signed h;
    int unsigned oldest;
    logic [TIME_W-1:0] dt;
    longint v;
    climb_result_t res;
    h = altitude_cm_of(p);
    oldest = (next_slot + 1) % HIST_DEPTH;
    alt_hist[next_slot] = h;
    time_hist[next_slot] = t;
    res.fresh = 1'b0;
    if (time_hist[oldest] != 0) begin
      dt = t - time_hist[oldest];
      if (dt != 0) begin
        v = ((longint'(h) - longint'(alt_hist[oldest])) * 1000) / longint'(dt);
        if (v > 1000000) v = 1000000;
        if (v < -1000000) v = -1000000;
        climb_rate = int'(v);
        res.fresh = 1'b1;
      end
    end
    next_slot = oldest;
    if (h > 0 && h > peak_cm) peak_cm = h;
    res.alt = h[ALT_W-1:0];
    res.vel = climb_rate[VEL_W-1:0];
    res.peak = peak_cm[PEAK_W-1:0];
    pending_results.push_back(res);
  endtask

  // Offer one sample; valid stays up back to back when there is no gap
  task automatic send_sample(logic [PRES_W-1:0] p, logic [TIME_W-1:0] t);
    int gap;
    gap = (!steady_flow && $urandom_range(0, 99) < 16) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pressure_pa <= p;
    in_time_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_climb(p, t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ground(logic [PRES_W-1:0] p0);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ground_pa = p0;
  endtask

  // Mostly a climbing clock with small steps; sometimes equal, zero or a big jump
  function automatic logic [TIME_W-1:0] next_time();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 8) return clock_ms;
    if (sel < 12) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(1, 200);
    return clock_ms;
  endfunction

  function automatic logic [PRES_W-1:0] rand_pressure();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 20) return PRES_W'($urandom_range(0, 131071));
    if (sel < 25) return 17'h1FFFF;
    return (ground_pa > 40000) ? PRES_W'($urandom_range(ground_pa - 40000, ground_pa + 3000))
                               : PRES_W'($urandom_range(1, 60000));
  endfunction

  task automatic test_corner_samples();
    send_sample(17'd101325, 32'd100);
    send_sample(17'd0, 32'd110);
    send_sample(17'h1FFFF, 32'd120);
    send_sample(17'd1, 32'd130);
    send_sample(17'd50000, 32'd0);
    send_sample(17'd60000, 32'd140);
    send_sample(17'd70000, 32'd140);
    send_sample(17'd80000, 32'd150);
    send_sample(17'd1, 32'd151);
    send_sample(17'h1FFFF, 32'd152);
    send_sample(17'd1, 32'd153);
    send_sample(17'd90000, 32'hFFFF_FFF0);
    send_sample(17'd95000, 32'hFFFF_FFFF);
    send_sample(17'd99000, 32'h0000_0010);
    send_sample(17'd101325, 32'h0000_0020);
    send_sample(17'd1, 32'h0000_0021);
    send_sample(17'h1FFFF, 32'hFFFF_FFFF);
    send_sample(17'd1, 32'h0000_0001);
  endtask

  task automatic test_ground_extremes();
    logic [PRES_W-1:0] p0s [0:2];
    p0s[0] = '0;
    p0s[1] = 17'd1;
    p0s[2] = 17'h1FFFF;
    foreach (p0s[j]) begin
      set_ground(p0s[j]);
      send_sample(17'd1, 32'd1000);
      send_sample(17'h1FFFF, 32'd1001);
      send_sample(17'd65535, 32'd1002);
      send_sample(17'd0, 32'd1003);
    end
  endtask

  task automatic test_random_flight(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 0) begin
        case ($urandom_range(0, 3))
          0: set_ground(17'd101325);
          1: set_ground(PRES_W'($urandom_range(80000, 110000)));
          2: set_ground(PRES_W'($urandom_range(1, 131071)));
          default: set_ground(17'h1FFFF);
        endcase
      end
      steady_flow = (i >= 1000 && i < 1200);
      send_sample(rand_pressure(), next_time());
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_output_stall();
    holdoff_left = 3000;
    for (int i = 0; i < 20; i++) send_sample(rand_pressure(), next_time());
  endtask

  // Receiver: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || ($urandom_range(0, 99) >= 16);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    climb_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction");
      end else begin
        want = pending_results.pop_front();
        if (want.fresh) fresh_seen++;
        if (want.alt !== out_altitude_cm || want.vel !== out_velocity_cm_s ||
            want.fresh !== out_velocity_fresh || want.peak !== out_peak_altitude_cm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp alt %0d vel %0d fresh %0d peak %0d, got %0d %0d %0d %0d",
                     want.alt, want.vel, want.fresh, want.peak, out_altitude_cm,
                     out_velocity_cm_s, out_velocity_fresh, out_peak_altitude_cm);
        end
      end
    end
  end

  initial begin
    model_reset();
    clock_ms = 32'd5000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_samples();
    test_ground_extremes();
    test_random_flight(RAND_ITEMS);
    test_output_stall();
    wait_idle();
    if (pending_results.size() != 0) mismatches++;
    $display("Checked %0d results (%0d with a new climb rate) over corner, ground-pressure,",
             results_seen, fresh_seen);
    $display("random-flight and output-stall phases; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
